FILE: rtl/core/kbd_pkg.sv
// Shared types, constants and helpers for the keyboard matrix debounce scanner.
// No dependencies; the rtl/core files other than kbd_stream_if use it by scoped names.
package kbd_pkg;

  // Field widths fixed by the item formats.
  localparam int TIME_W     = 16;
  localparam int IN_COLS    = 15;
  localparam int ROW_FIELD_W = 3;
  localparam int LEN_W      = 3;
  localparam int HIST_W     = 8;

  // Default matrix geometry.
  localparam int DEF_ROWS = 6;
  localparam int DEF_COLS = 15;

  // Configuration port layout and register indexes.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_PRESS_LEN   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_LEN = 1'd1;
  localparam logic [LEN_W-1:0]      LEN_RESET       = 3'd7;

  // History values that hold no edge.
  localparam logic [HIST_W-1:0] HIST_EMPTY = 8'h00;
  localparam logic [HIST_W-1:0] HIST_FULL  = 8'hFF;

  // One row sample.
  typedef struct packed {
    logic [TIME_W-1:0]  now_time;
    logic [IN_COLS-1:0] column_levels;
  } sample_t;

  // One scan report.
  typedef struct packed {
    logic                   scan_done;
    logic [ROW_FIELD_W-1:0] scanned_row;
    logic [IN_COLS-1:0]     row_keys;
    logic [ROW_FIELD_W-1:0] next_row;
  } report_t;

  // Control handed from the scan logic to the output stage.
  typedef struct packed {
    logic load;
    logic scan_done;
  } merge_ctl_t;

  // Mask of the newest n history bits; n of zero gives an empty mask.
  function automatic logic [HIST_W-1:0] low_mask(input logic [LEN_W-1:0] n);
    logic [HIST_W:0] ones;
    ones = (9'd1 << n) - 9'd1;
    return ones[HIST_W-1:0];
  endfunction

endpackage

FILE: rtl/core/kbd_stream_if.sv
// Valid/ready stream interface used for the sample and report channels.
// Depends on nothing; the payload type is given by the instantiating scope.
interface kbd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/kbd_lane.sv
// Debounce lane for one key: shifts the history and decides the key state.
// Uses kbd_pkg for widths and the history constants.
module kbd_lane (
  input  logic [kbd_pkg::HIST_W-1:0] hist,
  input  logic                       level,
  input  logic                       key,
  input  logic [kbd_pkg::HIST_W-1:0] pmask,
  input  logic [kbd_pkg::HIST_W-1:0] rmask,
  output logic [kbd_pkg::HIST_W-1:0] hist_next,
  output logic                       key_next
);

  logic mixed;
  logic press_hit;
  logic release_hit;

  // The newest sample enters at bit 0.
  assign hist_next = {hist[kbd_pkg::HIST_W-2:0], level};

  // Only a history that still holds an edge may change the key.
  assign mixed       = (hist_next != kbd_pkg::HIST_EMPTY) && (hist_next != kbd_pkg::HIST_FULL);
  assign press_hit   = (hist_next & pmask) == pmask;
  assign release_hit = (hist_next & rmask) == kbd_pkg::HIST_EMPTY;

  always_comb begin
    key_next = key;
    if (mixed) begin
      if (press_hit) begin
        key_next = 1'b1;
      end else if (release_hit) begin
        key_next = 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/kbd_out_stage.sv
// Output register: merges the lane results of one row into a scan report.
// Uses kbd_pkg for the report type and kbd_stream_if for the report channel.
module kbd_out_stage #(
  parameter int COLS = kbd_pkg::DEF_COLS,
  parameter int ROW_W = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  kbd_pkg::merge_ctl_t    ctl,
  input  logic [ROW_W-1:0]       row,
  input  logic [ROW_W-1:0]       row_after,
  input  logic [COLS-1:0]        keys,
  output logic                   room,
  kbd_stream_if.source           report
);

  logic                   valid;
  kbd_pkg::report_t       payload;
  logic [kbd_pkg::IN_COLS-1:0] keys_out;
  logic [ROW_W+2:0]       row_ext;
  logic [ROW_W+2:0]       after_ext;

  // Only columns that fit the report field are shown; missing columns read as zero.
  for (genvar i = 0; i < kbd_pkg::IN_COLS; i++) begin : g_keys
    if (i < COLS) begin : g_have
      assign keys_out[i] = keys[i];
    end else begin : g_none
      assign keys_out[i] = 1'b0;
    end
  end

  // Row indexes are reported modulo eight.
  assign row_ext   = {3'b000, row};
  assign after_ext = {3'b000, row_after};

  // A new transaction is taken when the register is empty or is draining.
  assign room = !valid || report.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= 1'b1;
    end else if (report.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      payload.scan_done   <= ctl.scan_done;
      payload.scanned_row <= row_ext[kbd_pkg::ROW_FIELD_W-1:0];
      payload.row_keys    <= keys_out;
      payload.next_row    <= after_ext[kbd_pkg::ROW_FIELD_W-1:0];
    end
  end

  assign report.valid   = valid;
  assign report.payload = payload;

endmodule

FILE: rtl/core/keyboard_matrix_debounce_scanner.sv
// Keyboard matrix scanner with one debounce lane per column.
// Depends on kbd_pkg, kbd_stream_if, kbd_lane and kbd_out_stage.
//
// Usage:
//   sample : one transaction per row sample (timer value, column levels of the
//            row last announced in next_row). Bit i set means key i pressed.
//   report : one transaction per sample: scan flag, row handled, debounced keys
//            of that row and the row to drive for the following sample.
//   cfg_*  : write port for press_len (index 0) and release_len (index 1);
//            write only while no transaction is in flight.
// A report is registered and valid in the cycle after its sample is accepted.
// Throughput: one sample per cycle while report is ready. All column lanes
// update the addressed row in the accepting cycle, so the next sample (the
// next row) can follow at once. A sample at row 0 whose timer equals the
// stored timestamp is reported as skipped and leaves all state untouched.
// Reset: histories, key states, row counter and timestamp clear to zero and
// both lengths return to 7; no report is pending afterwards.
// Stall: while report is held off, the pending report stays in the output
// register and sample is accepted only as that register drains.
module keyboard_matrix_debounce_scanner #(
  parameter int ROWS = kbd_pkg::DEF_ROWS,
  parameter int COLS = kbd_pkg::DEF_COLS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [kbd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [kbd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  kbd_stream_if.sink                      sample,
  kbd_stream_if.source                    report
);

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  logic [COLS-1:0][kbd_pkg::HIST_W-1:0] hist [ROWS];
  logic [COLS-1:0]                      deb  [ROWS];
  logic [ROW_W-1:0]                     row;
  logic [kbd_pkg::TIME_W-1:0]           last_ts;
  logic [kbd_pkg::LEN_W-1:0]            press_len;
  logic [kbd_pkg::LEN_W-1:0]            release_len;

  logic [kbd_pkg::HIST_W-1:0]           pmask;
  logic [kbd_pkg::HIST_W-1:0]           rmask;
  logic [COLS-1:0]                      levels;
  logic [COLS-1:0][kbd_pkg::HIST_W-1:0] hist_new;
  logic [COLS-1:0]                      deb_new;
  logic [ROW_W-1:0]                     row_inc;
  logic [ROW_W-1:0]                     row_after;
  logic [COLS-1:0]                      keys;
  logic                                 room;
  logic                                 accept;
  logic                                 skip;
  kbd_pkg::merge_ctl_t                  ctl;

  // Handshake and the timestamp check at row 0.
  assign sample.ready = room;
  assign accept       = sample.valid && room;
  assign skip         = (row == '0) && (sample.payload.now_time == last_ts);

  assign pmask = kbd_pkg::low_mask(press_len);
  assign rmask = kbd_pkg::low_mask(release_len);

  // Columns beyond the sampled width read as released.
  for (genvar c = 0; c < COLS; c++) begin : g_lane
    if (c < kbd_pkg::IN_COLS) begin : g_in
      assign levels[c] = sample.payload.column_levels[c];
    end else begin : g_out
      assign levels[c] = 1'b0;
    end

    kbd_lane u_lane (
      .hist      (hist[row][c]),
      .level     (levels[c]),
      .key       (deb[row][c]),
      .pmask     (pmask),
      .rmask     (rmask),
      .hist_next (hist_new[c]),
      .key_next  (deb_new[c])
    );
  end

  // Row counter advance with wrap.
  assign row_inc   = (row == LAST_ROW) ? '0 : row + 1'b1;
  assign row_after = skip ? '0 : row_inc;
  assign keys      = skip ? deb[row] : deb_new;

  assign ctl.load      = accept;
  assign ctl.scan_done = !skip;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      press_len   <= kbd_pkg::LEN_RESET;
      release_len <= kbd_pkg::LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        kbd_pkg::REG_PRESS_LEN:   press_len   <= cfg_wdata[kbd_pkg::LEN_W-1:0];
        kbd_pkg::REG_RELEASE_LEN: release_len <= cfg_wdata[kbd_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Scan state: histories and key states of the addressed row, row and timestamp.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        hist[r] <= '0;
        deb[r]  <= '0;
      end
      row     <= '0;
      last_ts <= '0;
    end else if (accept && !skip) begin
      hist[row] <= hist_new;
      deb[row]  <= deb_new;
      row       <= row_inc;
      if (row == '0) begin
        last_ts <= sample.payload.now_time;
      end
    end
  end

  kbd_out_stage #(
    .COLS  (COLS),
    .ROW_W (ROW_W)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .row       (row),
    .row_after (row_after),
    .keys      (keys),
    .room      (room),
    .report    (report)
  );

endmodule

FILE: rtl/core/kbd_checker.sv
// Port-level checks for the keyboard matrix debounce scanner, bound to the top level.
// Uses kbd_pkg for field widths; attaches to keyboard_matrix_debounce_scanner.
module kbd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               scan_done,
  input logic [kbd_pkg::ROW_FIELD_W-1:0]    scanned_row,
  input logic [kbd_pkg::IN_COLS-1:0]        row_keys,
  input logic [kbd_pkg::ROW_FIELD_W-1:0]    next_row
);

  // No report is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("report valid after reset");

  // Every accepted sample yields a report in the next cycle.
  a_accept_report: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted sample produced no report");

  // A stalled report holds its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(scan_done)
      && $stable(scanned_row) && $stable(row_keys) && $stable(next_row)))
    else $error("stalled report changed");

  // A skipped scan is always at row 0 and stays there.
  a_skip_rows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !scan_done) |-> (scanned_row == '0 && next_row == '0))
    else $error("skipped scan reports a nonzero row");

endmodule

bind keyboard_matrix_debounce_scanner kbd_checker u_kbd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (report.valid),
  .out_ready   (report.ready),
  .scan_done   (report.payload.scan_done),
  .scanned_row (report.payload.scanned_row),
  .row_keys    (report.payload.row_keys),
  .next_row    (report.payload.next_row)
);

FILE: bench/keyboard_matrix_debounce_scanner_tb.sv
// Self-checking testbench for the keyboard matrix debounce scanner.
// Depends on kbd_pkg, kbd_stream_if and keyboard_matrix_debounce_scanner from the RTL.
module keyboard_matrix_debounce_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS         = kbd_pkg::DEF_ROWS;
  localparam int COLS         = kbd_pkg::DEF_COLS;
  localparam int MAX_WAIT     = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int PHASE_COUNT  = 10;
  localparam int PHASE_ITEMS  = 130;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [kbd_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [kbd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  kbd_stream_if #(.payload_t(kbd_pkg::sample_t)) sample_ch ();
  kbd_stream_if #(.payload_t(kbd_pkg::report_t)) report_ch ();

  keyboard_matrix_debounce_scanner #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .sample   (sample_ch),
    .report   (report_ch)
  );

  // Predicted scanner state and configuration.
  logic [kbd_pkg::HIST_W-1:0]  key_hist  [ROWS][COLS];
  logic [kbd_pkg::IN_COLS-1:0] key_state [ROWS];
  int unsigned                 scan_row;
  logic [kbd_pkg::TIME_W-1:0]  scan_stamp;
  logic [kbd_pkg::LEN_W-1:0]   press_n;
  logic [kbd_pkg::LEN_W-1:0]   release_n;

  // Samples waiting to be sent and reports waiting to be seen.
  kbd_pkg::sample_t queued_samples [$];
  kbd_pkg::report_t expected_reports [$];
  int unsigned samples_issued;
  int unsigned reports_seen;
  int unsigned error_count;

  // Stimulus-side view of the row sequence and the intended key positions.
  int unsigned                 gen_row;
  logic [kbd_pkg::TIME_W-1:0]  gen_stamp;
  logic [kbd_pkg::IN_COLS-1:0] key_plan [ROWS];

  int  send_wait;
  bit  send_calm;
  int  recv_wait;
  bit  recv_calm;

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [kbd_pkg::HIST_W-1:0] newest_bits(
    input logic [kbd_pkg::LEN_W-1:0] n
  );
    logic [kbd_pkg::HIST_W-1:0] m;
    m = '0;
    for (int i = 0; i < kbd_pkg::HIST_W; i++) begin
      if (i < n) m[i] = 1'b1;
    end
    return m;
  endfunction

  task automatic clear_scan_state();
    for (int r = 0; r < ROWS; r++) begin
      key_state[r] = '0;
      for (int c = 0; c < COLS; c++) key_hist[r][c] = kbd_pkg::HIST_EMPTY;
    end
    scan_row   = 0;
    scan_stamp = '0;
    press_n    = kbd_pkg::LEN_RESET;
    release_n  = kbd_pkg::LEN_RESET;
  endtask

  // Advance the predicted state by one row sample and return its report.
  function automatic kbd_pkg::report_t debounce_row(input kbd_pkg::sample_t s);
    kbd_pkg::report_t           rep;
    int unsigned                row;
    logic [kbd_pkg::HIST_W-1:0] pmask;
    logic [kbd_pkg::HIST_W-1:0] rmask;
    logic [kbd_pkg::HIST_W-1:0] h;
    logic                       lvl;
    row   = (scan_row < ROWS) ? scan_row : 0;
    pmask = newest_bits(press_n);
    rmask = newest_bits(release_n);
    if (row == 0 && s.now_time == scan_stamp) begin
      rep.scan_done   = 1'b0;
      rep.scanned_row = '0;
      rep.row_keys    = key_state[0];
      rep.next_row    = '0;
      return rep;
    end
    if (row == 0) scan_stamp = s.now_time;
    for (int c = 0; c < COLS; c++) begin
      lvl = (c < kbd_pkg::IN_COLS) ? s.column_levels[c] : 1'b0;
      h = {key_hist[row][c][kbd_pkg::HIST_W-2:0], lvl};
      key_hist[row][c] = h;
      // A settled history leaves the key as it is.
      if (h != kbd_pkg::HIST_EMPTY && h != kbd_pkg::HIST_FULL && c < kbd_pkg::IN_COLS) begin
        if ((h & pmask) == pmask) key_state[row][c] = 1'b1;
        else if ((h & rmask) == '0) key_state[row][c] = 1'b0;
      end
    end
    scan_row = row + 1;
    if (scan_row >= ROWS) scan_row = 0;
    rep.scan_done   = 1'b1;
    rep.scanned_row = kbd_pkg::ROW_FIELD_W'(row);
    rep.row_keys    = key_state[row];
    rep.next_row    = kbd_pkg::ROW_FIELD_W'(scan_row);
    return rep;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got)
      flag_error($sformatf("%s expected %0d, got %0d", field, want, got));
  endtask

  // Queue one sample and follow the row sequence it will cause.
  task automatic queue_sample(input logic [kbd_pkg::TIME_W-1:0] t,
                              input logic [kbd_pkg::IN_COLS-1:0] lv);
    kbd_pkg::sample_t s;
    s.now_time      = t;
    s.column_levels = lv;
    if (!(gen_row == 0 && t == gen_stamp)) begin
      if (gen_row == 0) gen_stamp = t;
      gen_row = (gen_row + 1) % ROWS;
    end
    queued_samples.push_back(s);
    samples_issued++;
  endtask

  // Mostly steady key positions with occasional bounce, plus some raw noise.
  task automatic add_samples(input int count, input int noise_pct);
    logic [kbd_pkg::TIME_W-1:0]  t;
    logic [kbd_pkg::IN_COLS-1:0] lv;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        t  = kbd_pkg::TIME_W'($urandom_range(0, 65535));
        lv = kbd_pkg::IN_COLS'($urandom_range(0, 32767));
      end else begin
        if ($urandom_range(0, 7) == 0)
          key_plan[gen_row][$urandom_range(0, kbd_pkg::IN_COLS - 1)] ^= 1'b1;
        lv = key_plan[gen_row];
        if ($urandom_range(0, 5) == 0) lv[$urandom_range(0, kbd_pkg::IN_COLS - 1)] ^= 1'b1;
        if (gen_row != 0) begin
          t = kbd_pkg::TIME_W'($urandom_range(0, 65535));
        end else if ($urandom_range(0, 5) == 0) begin
          t = gen_stamp;
        end else if ($urandom_range(0, 1) == 1) begin
          t = gen_stamp + kbd_pkg::TIME_W'($urandom_range(1, 3));
        end else begin
          t = kbd_pkg::TIME_W'($urandom_range(0, 65535));
          if (t == gen_stamp) t = t + 1'b1;
        end
      end
      queue_sample(t, lv);
    end
  endtask

  task automatic write_reg(input logic [kbd_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [kbd_pkg::LEN_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == kbd_pkg::REG_PRESS_LEN) press_n = v;
    else release_n = v;
  endtask

  // Idle once every queued sample has produced its report.
  task automatic wait_idle();
    while (reports_seen != samples_issued) @(posedge clk);
  endtask

  // Sample driver: random gaps between transactions, held while stalled.
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      send_wait = 0;
      clear_scan_state();
    end else begin
      if (sample_ch.valid && sample_ch.ready)
        expected_reports.push_back(debounce_row(sample_ch.payload));
      if (!(sample_ch.valid && !sample_ch.ready)) begin
        if (send_wait > 0) begin
          send_wait--;
          sample_ch.valid <= 1'b0;
        end else if (queued_samples.size() > 0) begin
          sample_ch.valid   <= 1'b1;
          sample_ch.payload <= queued_samples.pop_front();
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          send_wait = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor: compares each transaction with the oldest prediction.
  always @(posedge clk) begin
    kbd_pkg::report_t want;
    kbd_pkg::report_t got;
    if (rst) begin
      report_ch.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (report_ch.valid && report_ch.ready) begin
        got = report_ch.payload;
        reports_seen++;
        if (expected_reports.size() == 0) begin
          flag_error($sformatf("report with no sample waiting: %h", got));
        end else begin
          want = expected_reports.pop_front();
          check_field("scan_done", 32'(want.scan_done), 32'(got.scan_done));
          check_field("scanned_row", 32'(want.scanned_row), 32'(got.scanned_row));
          check_field("row_keys", 32'(want.row_keys), 32'(got.row_keys));
          check_field("next_row", 32'(want.next_row), 32'(got.next_row));
        end
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus sequence: reset, directed samples, then random phases.
  initial begin
    logic [kbd_pkg::LEN_W-1:0] phase_press   [PHASE_COUNT];
    logic [kbd_pkg::LEN_W-1:0] phase_release [PHASE_COUNT];
    phase_press   = '{3'd7, 3'd1, 3'd0, 3'd3, 3'd7, 3'd1, 3'd0, 3'd7, 3'd2, 3'd5};
    phase_release = '{3'd7, 3'd1, 3'd0, 3'd5, 3'd1, 3'd7, 3'd7, 3'd0, 3'd4, 3'd2};
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_addr           = '0;
    cfg_wdata          = '0;
    sample_ch.valid    = 1'b0;
    sample_ch.payload  = '0;
    report_ch.ready    = 1'b0;
    samples_issued     = 0;
    reports_seen       = 0;
    error_count        = 0;
    gen_row            = 0;
    gen_stamp          = '0;
    send_calm          = 1'b0;
    recv_calm          = 1'b0;
    for (int r = 0; r < ROWS; r++) key_plan[r] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset lengths: a skipped first scan, field extremes, a repeated stamp.
    queue_sample(16'h0000, 15'h7FFF);
    queue_sample(16'hFFFF, 15'h7FFF);
    queue_sample(16'h0000, 15'h0000);
    queue_sample(16'hFFFF, 15'h5555);
    queue_sample(16'h1234, 15'h2AAA);
    queue_sample(16'h0000, 15'h7FFF);
    queue_sample(16'hFFFF, 15'h0000);
    queue_sample(16'hFFFF, 15'h7FFF);
    queue_sample(16'h0000, 15'h7FFF);
    wait_idle();

    // Shortest lengths: keys follow a single sample.
    write_reg(kbd_pkg::REG_PRESS_LEN, 3'd1);
    write_reg(kbd_pkg::REG_RELEASE_LEN, 3'd1);
    for (int i = 0; i < 12; i++)
      queue_sample(kbd_pkg::TIME_W'(100 + i), (i < 6) ? 15'h7FFF : 15'h0000);
    wait_idle();

    // Zero lengths: any mixed history sets the key.
    write_reg(kbd_pkg::REG_PRESS_LEN, 3'd0);
    write_reg(kbd_pkg::REG_RELEASE_LEN, 3'd0);
    for (int i = 0; i < 6; i++) queue_sample(kbd_pkg::TIME_W'(200 + i), 15'h1555);
    wait_idle();

    // Random phases over a spread of length settings.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_reg(kbd_pkg::REG_PRESS_LEN, phase_press[p]);
      write_reg(kbd_pkg::REG_RELEASE_LEN, phase_release[p]);
      add_samples(PHASE_ITEMS, (p % 3 == 2) ? 40 : 15);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0)
      flag_error($sformatf("%0d reports never arrived", expected_reports.size()));
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
